// ----- rtl/i2rd_pkg.sv -----
// i2rd_pkg: request types, character constants and digit encoding for the
// integer to radix digit converter. No dependencies.
package i2rd_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int DIGIT_W     = 6;
  localparam int COUNT_W     = 7;
  localparam int RADIX_W     = 6;
  localparam int SYMBOL_W    = 7;
  localparam int DIV_BITS    = 8;

  localparam logic [RADIX_W-1:0]  RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0]  RADIX_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0]  DEC_DIGITS  = 6'd10;
  localparam logic [SYMBOL_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [SYMBOL_W-1:0] ASCII_A     = 7'h41;
  localparam logic [SYMBOL_W-1:0] ASCII_MINUS = 7'h2D;

  typedef struct packed {
    logic signed [63:0]  value;
    logic [RADIX_W-1:0]  radix;
  } in_req_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
  } out_req_t;

  function automatic logic [SYMBOL_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [SYMBOL_W-1:0] r;
    if (d < DEC_DIGITS) begin
      r = ASCII_ZERO + SYMBOL_W'(d);
    end else begin
      r = ASCII_A + SYMBOL_W'(d - DEC_DIGITS);
    end
    return r;
  endfunction

endpackage

// ----- rtl/i2rd_ram.sv -----
// i2rd_ram: generic single write port, single read port ram with registered
// read data. No dependencies.
module i2rd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/integer_to_radix_digits.sv -----
// integer_to_radix_digits: signed integer to ascii digits in radix 2..36, one request at a time
// uses i2rd_pkg and one i2rd_ram as the digit store; reset clears sequencer and output valid
// a request with D digits: D divisions, each in steps of 8 quotient bits a cycle, then per
//   character a store read and an output load, after a leading '-' if negative; loads wait on stalls
// no new request is taken until the last character has been loaded
module integer_to_radix_digits #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  i2rd_pkg::in_req_t in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output i2rd_pkg::out_req_t out_o
);

  // magnitude width, padded to whole divider steps
  localparam int MW     = VALUE_WIDTH - 1;
  localparam int NSTEP  = (MW + i2rd_pkg::DIV_BITS - 1) / i2rd_pkg::DIV_BITS;
  localparam int PW     = NSTEP * i2rd_pkg::DIV_BITS;
  localparam int SW     = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                      state_q, state_d;
  logic [SW-1:0]                   step_q, step_d;
  logic [i2rd_pkg::COUNT_W-1:0]    count_q, count_d;
  logic [i2rd_pkg::ADDR_W-1:0]     idx_q, idx_d;
  logic                            neg_q, neg_d;
  logic [i2rd_pkg::RADIX_W-1:0]    radix_q, radix_d;
  logic [PW-1:0]                   div_q, div_d;
  logic [i2rd_pkg::DIGIT_W-1:0]    rem_q, rem_d;
  logic                            out_valid_q, out_valid_d;
  i2rd_pkg::out_req_t              out_q, out_d;

  // input decode: sign, saturated magnitude, clamped radix
  logic [VALUE_WIDTH-1:0]          in_val;
  logic [VALUE_WIDTH-1:0]          in_neg_val;
  logic                            in_neg;
  logic [MW-1:0]                   in_mag;
  logic [i2rd_pkg::RADIX_W-1:0]    in_radix;
  logic                            in_accept;

  // divider step results
  logic [i2rd_pkg::DIGIT_W-1:0]    step_rem;
  logic [i2rd_pkg::DIV_BITS-1:0]   step_quo;
  logic [PW-1:0]                   div_next;
  logic                            last_step;

  // store ports
  logic                            ram_we;
  logic                            ram_re;
  logic [i2rd_pkg::DIGIT_W-1:0]    ram_rdata;

  logic                            out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    in_val     = in_i.value[VALUE_WIDTH-1:0];
    in_neg     = in_val[VALUE_WIDTH-1];
    in_neg_val = ~in_val + VALUE_WIDTH'(1);
    if (!in_neg) begin
      in_mag = in_val[MW-1:0];
    end else if (in_neg_val[VALUE_WIDTH-1]) begin
      // most negative value saturates to the largest magnitude
      in_mag = '1;
    end else begin
      in_mag = in_neg_val[MW-1:0];
    end
    if (in_i.radix < i2rd_pkg::RADIX_MIN) begin
      in_radix = i2rd_pkg::RADIX_MIN;
    end else if (in_i.radix > i2rd_pkg::RADIX_MAX) begin
      in_radix = i2rd_pkg::RADIX_MAX;
    end else begin
      in_radix = in_i.radix;
    end
  end

  // restoring division, eight dividend bits per cycle, msb first
  always_comb begin
    logic [i2rd_pkg::DIGIT_W:0] trial;
    step_rem = rem_q;
    step_quo = '0;
    for (int b = 0; b < i2rd_pkg::DIV_BITS; b++) begin
      trial = {step_rem, div_q[PW-1-b]};
      if (trial >= {1'b0, radix_q}) begin
        trial = trial - {1'b0, radix_q};
        step_quo[i2rd_pkg::DIV_BITS-1-b] = 1'b1;
      end
      step_rem = trial[i2rd_pkg::DIGIT_W-1:0];
    end
  end

  assign div_next  = (div_q << i2rd_pkg::DIV_BITS) | PW'(step_quo);
  assign last_step = (step_q == SW'(NSTEP - 1));

  // digit written when the last step of a division finishes
  assign ram_we = (state_q == S_DIV) && last_step;
  assign ram_re = (state_q == S_RD);

  i2rd_ram #(
    .WIDTH (i2rd_pkg::DIGIT_W),
    .DEPTH (i2rd_pkg::STORE_DEPTH)
  ) u_digit_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[i2rd_pkg::ADDR_W-1:0]),
    .wdata_i (step_rem),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // sequencer: divide into the store, then emit a '-' if negative and read the store back in reverse
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    radix_d     = radix_q;
    div_d       = div_q;
    rem_d       = rem_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          neg_d   = in_neg;
          radix_d = in_radix;
          div_d   = PW'(in_mag);
          rem_d   = '0;
          step_d  = '0;
          count_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        div_d = div_next;
        if (last_step) begin
          // digit done: quotient stays in div_q for the next digit
          rem_d   = '0;
          step_d  = '0;
          count_d = count_q + i2rd_pkg::COUNT_W'(1);
          if (div_next == '0) begin
            idx_d   = count_q[i2rd_pkg::ADDR_W-1:0];
            state_d = neg_q ? S_SIGN : S_RD;
          end
        end else begin
          rem_d  = step_rem;
          step_d = step_q + SW'(1);
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_d.symbol = i2rd_pkg::ASCII_MINUS;
          out_d.last   = 1'b0;
          out_valid_d  = 1'b1;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        // read data holds until the next read is issued
        if (out_free) begin
          out_d.symbol = i2rd_pkg::digit_to_ascii(ram_rdata);
          out_d.last   = (idx_q == '0);
          out_valid_d  = 1'b1;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - i2rd_pkg::ADDR_W'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      neg_q       <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      neg_q       <= neg_d;
      step_q      <= step_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    radix_q <= radix_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // an accepted request keeps the input side stalled the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after accept");

  // divisor stays in the clamped range while dividing
  a_radix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (radix_q >= i2rd_pkg::RADIX_MIN) &&
                           (radix_q <= i2rd_pkg::RADIX_MAX))
    else $error("radix out of range during division");

  // partial remainder is always below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < radix_q))
    else $error("partial remainder not below radix");

  // digit count never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < i2rd_pkg::COUNT_W'(i2rd_pkg::STORE_DEPTH))
    else $error("digit count beyond store depth");

endmodule
